FILE: src/sle_pkg.sv
// sle_pkg: shared constants, codes and types of the serial line editor
// no dependencies; imported by every other file of the block
package sle_pkg;

  // line geometry
  localparam int LINE_MAX = 32;
  localparam int FILL_W   = $clog2(LINE_MAX + 1);
  localparam int IDX_W    = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int CHAR_W   = 7;

  // fixed field widths of the channels
  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int LEN_W  = 6;

  // command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // byte codes
  localparam logic [BYTE_W-1:0] BYTE_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] BYTE_TILDE = 8'h7E;
  localparam logic [BYTE_W-1:0] BYTE_NUL   = 8'h00;

  // result item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ECHO = 2'd0,
    KIND_CHAR = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  // commands from the front to the back
  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_ERASE = 2'd1,
    CMD_LINE  = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic [CHAR_W-1:0]  ch;
    logic [IDX_W-1:0]   idx;
    logic [FILL_W-1:0]  len;
  } cmd_t;

  // queue write side and read side
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_rd_t;

  // back end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'd0,
    ST_ECHO = 4'd1,
    ST_BS1  = 4'd2,
    ST_SP   = 4'd3,
    ST_BS2  = 4'd4,
    ST_NL   = 4'd5,
    ST_RD   = 4'd6,
    ST_CH   = 4'd7,
    ST_END  = 4'd8
  } back_state_t;

endpackage

FILE: src/sle_ifs.sv
// sle_in_if and sle_out_if: valid/ready channels of the serial line editor
// depends on sle_pkg for the field widths
interface sle_in_if;
  import sle_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sle_out_if;
  import sle_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] out_kind;
  logic [BYTE_W-1:0] out_byte;
  logic [LEN_W-1:0]  line_length;
  logic              last;

  modport source (output valid, output out_kind, output out_byte, output line_length,
                  output last, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input line_length,
                  input last, output ready);
endinterface

FILE: src/serial_line_editor.sv
// serial_line_editor: a byte that gives a result is pushed into the command queue, popped into the
// sequencer's command register and sent from the output register as its first result transaction;
// an echo loads each of its results into the output register, and a readout reads each stored character
// from the line store before loading it (memory read then output register); input is taken whenever
// the 2-entry command queue has room, and bytes that give no result are still taken by the front.
// synchronous active-low reset clears fill count, skip flag, queue and sequencer; the line store has no reset
module serial_line_editor
  import sle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  sle_in_if.sink     in_ch,
  sle_out_if.source  out_ch
);

  // front to queue
  q_wr_t q_wr;
  logic  q_full;
  // queue to back
  q_rd_t q_rd;
  logic  q_pop;

  // front: byte classification, fill count and terminator skip flag
  sle_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  // decoupling queue so the front keeps taking bytes during a readout while the queue has room
  sle_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .full  (q_full),
    .q_rd  (q_rd),
    .pop   (q_pop)
  );

  // back: line store, echo sequences and line streaming
  sle_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> !q_full)
    else $error("command pushed into full queue");

  // a line end closes its transaction group and never reports more than a full line
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_kind == KIND_END) |->
      (out_ch.last && out_ch.line_length <= LEN_W'(LINE_MAX) && out_ch.out_byte == BYTE_NUL))
    else $error("bad line end transaction");

  // stored characters are 7-bit and are always followed by more of the line
  a_char_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_kind == KIND_CHAR) |-> (!out_ch.last && !out_ch.out_byte[7]))
    else $error("bad line character transaction");

  // the back only takes a command when the queue holds one
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_rd.valid)
    else $error("pop from empty queue");

endmodule

FILE: src/sle_cmd_fifo.sv
// sle_cmd_fifo: short command queue between front and back
// depends on sle_pkg
module sle_cmd_fifo
  import sle_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  q_wr_t q_wr,
  output logic  full,
  output q_rd_t q_rd,
  input  logic  pop
);

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_rd.valid = (count_r != '0);
  assign q_rd.cmd   = entry_r[rd_ptr_r];
  assign do_push    = q_wr.push && !full;
  assign do_pop     = pop && q_rd.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= q_wr.cmd;
  end

endmodule

FILE: src/sle_front.sv
// sle_front: takes received bytes, classifies them, keeps fill count and skip flag
// depends on sle_pkg and sle_in_if; issues commands into sle_cmd_fifo
module sle_front
  import sle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  sle_in_if.sink      in_ch,
  input  logic        q_full,
  output q_wr_t       q_wr
);

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              skip_r, skip_nxt;
  logic              accept;
  logic              is_term, is_bs, is_print;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    is_term  = in_ch.rx_byte inside {BYTE_CR, BYTE_LF};
    is_bs    = (in_ch.rx_byte == BYTE_BS);
    is_print = in_ch.rx_byte inside {[BYTE_SP:BYTE_TILDE]};
  end

  always_comb begin
    fill_nxt     = fill_r;
    skip_nxt     = skip_r;
    q_wr.push    = 1'b0;
    q_wr.cmd.op  = CMD_PUT;
    q_wr.cmd.ch  = in_ch.rx_byte[CHAR_W-1:0];
    q_wr.cmd.idx = fill_r[IDX_W-1:0];
    q_wr.cmd.len = fill_r;
    if (accept) begin
      if (is_term) begin
        if (skip_r) begin
          skip_nxt = 1'b0;
        end else begin
          q_wr.push   = 1'b1;
          q_wr.cmd.op = CMD_LINE;
          fill_nxt    = '0;
          skip_nxt    = 1'b1;
        end
      end else begin
        skip_nxt = 1'b0;
        if (is_bs && fill_r != '0) begin
          q_wr.push   = 1'b1;
          q_wr.cmd.op = CMD_ERASE;
          fill_nxt    = fill_r - 1'b1;
        end else if (is_print && fill_r < FILL_W'(LINE_MAX)) begin
          q_wr.push   = 1'b1;
          q_wr.cmd.op = CMD_PUT;
          fill_nxt    = fill_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      skip_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      skip_r <= skip_nxt;
    end
  end

endmodule

FILE: src/sle_back.sv
// sle_back: carries out commands, holds the line store and drives result transactions
// depends on sle_pkg and sle_out_if; fed by sle_cmd_fifo
module sle_back
  import sle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  q_rd_t      q_rd,
  output logic       pop,
  sle_out_if.source  out_ch
);

  logic [CHAR_W-1:0] line_mem [LINE_MAX];
  logic [CHAR_W-1:0] rd_data_r;

  back_state_t       state_r, state_nxt;
  cmd_t              cmd_r;
  logic [FILL_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [FILL_W-1:0] rd_cnt_inc;

  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [LEN_W-1:0]  out_len_r;
  logic              out_last_r;

  logic              load_en, emit, mem_re, mem_we;
  kind_t             e_kind;
  logic [BYTE_W-1:0] e_byte;
  logic [LEN_W-1:0]  e_len;
  logic              e_last;

  assign load_en    = !out_valid_r || out_ch.ready;
  assign rd_cnt_inc = rd_cnt_r + 1'b1;
  assign mem_we     = pop && q_rd.cmd.op == CMD_PUT;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          case (q_rd.cmd.op)
            CMD_PUT:   state_nxt = ST_ECHO;
            CMD_ERASE: state_nxt = ST_BS1;
            CMD_LINE:  state_nxt = ST_NL;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ECHO: if (emit) state_nxt = ST_IDLE;
      ST_BS1:  if (emit) state_nxt = ST_SP;
      ST_SP:   if (emit) state_nxt = ST_BS2;
      ST_BS2:  if (emit) state_nxt = ST_IDLE;
      ST_NL:   if (emit) state_nxt = (cmd_r.len == '0) ? ST_END : ST_RD;
      ST_RD:   state_nxt = ST_CH;
      ST_CH:   if (emit) state_nxt = (rd_cnt_inc < cmd_r.len) ? ST_RD : ST_END;
      ST_END:  if (emit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop        = 1'b0;
    mem_re     = 1'b0;
    emit       = 1'b0;
    e_kind     = KIND_ECHO;
    e_byte     = BYTE_NUL;
    e_len      = '0;
    e_last     = 1'b0;
    rd_cnt_nxt = rd_cnt_r;
    case (state_r)
      ST_IDLE: pop = q_rd.valid;
      ST_ECHO: begin
        emit   = load_en;
        e_byte = {1'b0, cmd_r.ch};
        e_last = 1'b1;
      end
      ST_BS1: begin
        emit   = load_en;
        e_byte = BYTE_BS;
      end
      ST_SP: begin
        emit   = load_en;
        e_byte = BYTE_SP;
      end
      ST_BS2: begin
        emit   = load_en;
        e_byte = BYTE_BS;
        e_last = 1'b1;
      end
      ST_NL: begin
        emit   = load_en;
        e_byte = BYTE_LF;
        if (load_en) rd_cnt_nxt = '0;
      end
      ST_RD: mem_re = 1'b1;
      ST_CH: begin
        emit   = load_en;
        e_kind = KIND_CHAR;
        e_byte = {1'b0, rd_data_r};
        if (load_en) rd_cnt_nxt = rd_cnt_inc;
      end
      ST_END: begin
        emit   = load_en;
        e_kind = KIND_END;
        e_len  = LEN_W'(cmd_r.len);
        e_last = 1'b1;
      end
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rd_cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      if (emit)              out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) cmd_r <= q_rd.cmd;
    if (emit) begin
      out_kind_r <= e_kind;
      out_byte_r <= e_byte;
      out_len_r  <= e_len;
      out_last_r <= e_last;
    end
  end

  // line store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) line_mem[q_rd.cmd.idx] <= q_rd.cmd.ch;
    if (mem_re) rd_data_r <= line_mem[rd_cnt_r[IDX_W-1:0]];
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_kind    = out_kind_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.line_length = out_len_r;
  assign out_ch.last        = out_last_r;

endmodule
